FILE: design/rbsi_pkg.sv
// ---------------------------------------------------------------------------
// rbsi_pkg
// Types and constants shared by the ray/box slab intersection core.
// ---------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

  localparam int NUM_PLANES = 6;
  localparam int QUO_W      = 32;
  localparam int NUM_W      = 49;

  localparam logic [31:0] T_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN   = 32'h8000_0000;

  // request: ray origin and direction, signed Q16.16
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } rbsi_req_t;

  // result: hit flag, entry parameter and entry point
  typedef struct packed {
    logic               hit;
    logic        [30:0] hit_t;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } rbsi_res_t;

  // per-plane divider lane
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [31:0]      den;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             pneg;
    logic             pz;
    logic             qok;
    logic             ovf;
  } rbsi_div_t;

  typedef struct packed {
    logic                            v;
    rbsi_req_t                       ray;
    rbsi_div_t [NUM_PLANES-1:0]      pl;
  } rbsi_dstage_t;

  typedef struct packed {
    logic                            v;
    rbsi_req_t                       ray;
    logic                            ok;
    logic signed [31:0]              lo;
    logic signed [31:0]              hi;
    logic [NUM_PLANES-1:0][31:0]     r;
    logic [NUM_PLANES-1:0]           pneg;
    logic [NUM_PLANES-1:0]           pz;
    logic [NUM_PLANES-1:0]           qok;
  } rbsi_cstage_t;

endpackage

`default_nettype wire

FILE: design/ray_box_slab_intersect_core.sv
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_core
// Pipelined ray against axis-aligned box test by slab clipping, Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   The box is loaded through cfg_we_i / cfg_idx_i / cfg_data_i (index 0..5:
//   min x, y, z, max x, y, z); a write takes effect at once, indexes 6 and 7
//   are ignored. Load the box only while no request is in flight.
//   A request (ray origin and direction) is taken at every rising edge with
//   start_i high and busy_o low. busy_o is always low: the core takes one
//   request per cycle.
//   Each request gives one result on res_o, marked by done_o for exactly one
//   cycle. Results leave in request order.
//   The pipeline holds the bit-serial quotient stages: one stage per
//   quotient bit (32) for the six plane divisions, plus operand setup,
//   saturation, six clipping stages (one per plane), the multiply stage and
//   the output register.
//   The receiver cannot stall; results are presented once and not held.
//   Reset clears the box registers and all pipeline valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect_core
  import rbsi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire rbsi_req_t   req_i,
  output logic             done_o,
  output rbsi_res_t        res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int NDIV = QUO_W;

  // box registers
  logic signed [31:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0; min_y_q <= '0; min_z_q <= '0;
      max_x_q <= '0; max_y_q <= '0; max_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_MIN_X: min_x_q <= cfg_data_i;
        REG_BOX_MIN_Y: min_y_q <= cfg_data_i;
        REG_BOX_MIN_Z: min_z_q <= cfg_data_i;
        REG_BOX_MAX_X: max_x_q <= cfg_data_i;
        REG_BOX_MAX_Y: max_y_q <= cfg_data_i;
        REG_BOX_MAX_Z: max_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // operand setup: slab p and q per plane (z-min, z-max, y-min, y-max, x-min, x-max)
  logic [32:0]  pl_p [NUM_PLANES];
  logic [32:0]  pl_q [NUM_PLANES];
  rbsi_dstage_t dst_d [NDIV+1];
  rbsi_dstage_t dst_q [NDIV+1];

  always_comb begin
    logic [32:0] pabs;
    logic [32:0] qabs;
    logic [63:0] dv;
    pl_p[0] = -{req_i.dir_z[31], req_i.dir_z};
    pl_q[0] = {req_i.origin_z[31], req_i.origin_z} - {min_z_q[31], min_z_q};
    pl_p[1] = {req_i.dir_z[31], req_i.dir_z};
    pl_q[1] = {max_z_q[31], max_z_q} - {req_i.origin_z[31], req_i.origin_z};
    pl_p[2] = -{req_i.dir_y[31], req_i.dir_y};
    pl_q[2] = {req_i.origin_y[31], req_i.origin_y} - {min_y_q[31], min_y_q};
    pl_p[3] = {req_i.dir_y[31], req_i.dir_y};
    pl_q[3] = {max_y_q[31], max_y_q} - {req_i.origin_y[31], req_i.origin_y};
    pl_p[4] = -{req_i.dir_x[31], req_i.dir_x};
    pl_q[4] = {req_i.origin_x[31], req_i.origin_x} - {min_x_q[31], min_x_q};
    pl_p[5] = {req_i.dir_x[31], req_i.dir_x};
    pl_q[5] = {max_x_q[31], max_x_q} - {req_i.origin_x[31], req_i.origin_x};

    dst_d[0].v   = start_i;
    dst_d[0].ray = req_i;
    for (int j = 0; j < NUM_PLANES; j++) begin
      pabs = pl_p[j][32] ? -pl_p[j] : pl_p[j];
      qabs = pl_q[j][32] ? -pl_q[j] : pl_q[j];
      dst_d[0].pl[j].rem  = {qabs, 16'h0000};
      dst_d[0].pl[j].den  = pabs[31:0];
      dst_d[0].pl[j].quo  = '0;
      dst_d[0].pl[j].neg  = pl_q[j][32] ^ pl_p[j][32];
      dst_d[0].pl[j].pneg = pl_p[j][32];
      dst_d[0].pl[j].pz   = (pl_p[j] == 33'd0);
      dst_d[0].pl[j].qok  = !pl_q[j][32];
      // quotient of 2^32 or more saturates in any case
      dst_d[0].pl[j].ovf  = ({15'd0, qabs[32:16]} >= pabs[31:0]);
    end

    // restoring division, one quotient bit per stage
    for (int k = 0; k < NDIV; k++) begin
      dst_d[k+1] = dst_q[k];
      for (int j = 0; j < NUM_PLANES; j++) begin
        // shifted divisor kept at full width so high divisor bits are not lost
        dv = 64'(dst_q[k].pl[j].den) << (NDIV - 1 - k);
        if ({15'd0, dst_q[k].pl[j].rem} >= dv) begin
          dst_d[k+1].pl[j].rem = dst_q[k].pl[j].rem - dv[NUM_W-1:0];
          dst_d[k+1].pl[j].quo[NDIV-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NDIV; k++) dst_q[k] <= '0;
    end else begin
      for (int k = 0; k <= NDIV; k++) dst_q[k] <= dst_d[k];
    end
  end

  // quotient saturation, then clipping one plane per stage
  rbsi_cstage_t cst_d [NUM_PLANES+1];
  rbsi_cstage_t cst_q [NUM_PLANES+1];

  always_comb begin
    rbsi_div_t dl;
    logic      big;
    cst_d[0].v   = dst_q[NDIV].v;
    cst_d[0].ray = dst_q[NDIV].ray;
    cst_d[0].ok  = 1'b1;
    cst_d[0].lo  = '0;
    cst_d[0].hi  = T_MAX;
    for (int j = 0; j < NUM_PLANES; j++) begin
      dl = dst_q[NDIV].pl[j];
      if (dl.neg) begin
        big = dl.ovf | (dl.quo[31] & (|dl.quo[30:0]));
        cst_d[0].r[j] = big ? T_MIN : -dl.quo;
      end else begin
        big = dl.ovf | dl.quo[31];
        cst_d[0].r[j] = big ? T_MAX : dl.quo;
      end
      cst_d[0].pneg[j] = dl.pneg;
      cst_d[0].pz[j]   = dl.pz;
      cst_d[0].qok[j]  = dl.qok;
    end

    for (int j = 0; j < NUM_PLANES; j++) begin
      cst_d[j+1] = cst_q[j];
      if (cst_q[j].ok) begin
        if (cst_q[j].pz[j]) begin
          if (!cst_q[j].qok[j]) cst_d[j+1].ok = 1'b0;
        end else if (cst_q[j].pneg[j]) begin
          if ($signed(cst_q[j].r[j]) > cst_q[j].hi) cst_d[j+1].ok = 1'b0;
          else if ($signed(cst_q[j].r[j]) > cst_q[j].lo) cst_d[j+1].lo = cst_q[j].r[j];
        end else begin
          if ($signed(cst_q[j].r[j]) < cst_q[j].lo) cst_d[j+1].ok = 1'b0;
          else if ($signed(cst_q[j].r[j]) < cst_q[j].hi) cst_d[j+1].hi = cst_q[j].r[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NUM_PLANES; k++) cst_q[k] <= '0;
    end else begin
      for (int k = 0; k <= NUM_PLANES; k++) cst_q[k] <= cst_d[k];
    end
  end

  // direction times entry parameter
  logic               mul_v_q, mul_hit_q;
  logic        [30:0] mul_t_q;
  logic signed [31:0] mul_ox_q, mul_oy_q, mul_oz_q;
  logic signed [63:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [32:0] t_s;

  assign t_s = {2'b00, cst_q[NUM_PLANES].lo[30:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= cst_q[NUM_PLANES].v;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_hit_q <= cst_q[NUM_PLANES].ok;
    mul_t_q   <= cst_q[NUM_PLANES].lo[30:0];
    mul_ox_q  <= cst_q[NUM_PLANES].ray.origin_x;
    mul_oy_q  <= cst_q[NUM_PLANES].ray.origin_y;
    mul_oz_q  <= cst_q[NUM_PLANES].ray.origin_z;
    prod_x_q  <= 64'(cst_q[NUM_PLANES].ray.dir_x * t_s);
    prod_y_q  <= 64'(cst_q[NUM_PLANES].ray.dir_y * t_s);
    prod_z_q  <= 64'(cst_q[NUM_PLANES].ray.dir_z * t_s);
  end

  // floor shift, origin add and saturation
  function automatic logic [31:0] pt_sat(input logic signed [63:0] prod,
                                         input logic signed [31:0] o);
    logic signed [63:0] sh;
    logic signed [64:0] s;
    sh = prod >>> 16;
    s  = $signed({sh[63], sh}) + $signed({{33{o[31]}}, o});
    if (s > 65'sd2147483647)       pt_sat = T_MAX;
    else if (s < -65'sd2147483648) pt_sat = T_MIN;
    else                           pt_sat = s[31:0];
  endfunction

  logic      done_q;
  rbsi_res_t res_q, res_d;

  always_comb begin
    res_d = '0;
    if (mul_hit_q) begin
      res_d.hit     = 1'b1;
      res_d.hit_t   = mul_t_q;
      res_d.point_x = pt_sat(prod_x_q, mul_ox_q);
      res_d.point_y = pt_sat(prod_y_q, mul_oy_q);
      res_d.point_z = pt_sat(prod_z_q, mul_oz_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |-> (res_o.hit_t == '0 && res_o.point_x == '0 &&
      res_o.point_y == '0 && res_o.point_z == '0))
    else $error("miss result carries nonzero fields");

  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cst_q[NUM_PLANES].v && cst_q[NUM_PLANES].ok) |->
      (cst_q[NUM_PLANES].lo >= 0 && cst_q[NUM_PLANES].lo <= cst_q[NUM_PLANES].hi))
    else $error("clipped interval inverted on a hit");

  a_mul_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_v_q |=> done_o)
    else $error("multiply stage request lost before output");

endmodule

`default_nettype wire
